@@ sv/urm_pkg.sv @@
// shared types and constants for the unbiased range mapper
// no dependencies
package urm_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_RANGE_LOW  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_RANGE_HIGH = cfg_idx_t'(1);

  typedef logic [WordW-1:0] word_t;

  // what travels from one divider cell to the next
  typedef struct packed {
    logic  valid;
    word_t word;
    word_t rem;
  } cell_bus_t;

  // range facts derived from the configuration registers
  typedef struct packed {
    logic  low_gt_high;
    logic  span_zero;
    logic  non_pow2;
    word_t span;
    word_t low;
  } range_info_t;

endpackage

@@ sv/urm_cell.sv @@
// one restoring-division cell: brings in one bit of the word, subtracts span if it fits
// depends on urm_pkg
module urm_cell #(
  parameter int unsigned BitIdx = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  urm_pkg::word_t    span,
  input  urm_pkg::cell_bus_t din,
  output urm_pkg::cell_bus_t dout
);
  import urm_pkg::*;

  logic [WordW:0] shifted;
  logic [WordW:0] diff;
  word_t          rem_next;

  always_comb begin
    shifted = {din.rem, din.word[BitIdx]};
    diff    = shifted - {1'b0, span};
    if (shifted >= {1'b0, span}) begin
      rem_next = diff[WordW-1:0];
    end else begin
      rem_next = shifted[WordW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (advance) begin
      dout.valid <= din.valid;
    end
    if (advance) begin
      dout.word <= din.word;
      dout.rem  <= rem_next;
    end
  end

endmodule

@@ sv/urm_tail.sv @@
// end of the chain: rejection test, special ranges and the output register
// depends on urm_pkg
module urm_tail (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  urm_pkg::range_info_t info,
  input  urm_pkg::cell_bus_t  din,
  output logic                out_valid,
  output urm_pkg::word_t      value,
  output logic                status
);
  import urm_pkg::*;

  logic  a_valid;
  word_t a_word;
  word_t a_rem;
  word_t a_base;

  logic [WordW:0] top_sum;
  logic           reject;
  logic           out_valid_next;
  word_t          value_next;
  logic           status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= din.valid;
    end
    if (advance) begin
      a_word <= din.word;
      a_rem  <= din.rem;
      a_base <= din.word - din.rem;
    end
  end

  // word falls in the last incomplete bucket when the next multiple overflows
  always_comb begin
    top_sum = {1'b0, a_base} + {1'b0, info.span};
    reject  = info.non_pow2 && top_sum[WordW];
    status_next = 1'b0;
    out_valid_next = a_valid;
    if (info.low_gt_high) begin
      value_next  = '0;
      status_next = 1'b1;
    end else if (info.span_zero) begin
      value_next = a_word;
    end else begin
      value_next = a_rem + info.low;
      out_valid_next = a_valid && !reject;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= out_valid_next;
    end
    if (advance) begin
      value  <= value_next;
      status <= status_next;
    end
  end

endmodule

@@ sv/unbiased_range_mapper_top.sv @@
// top level of the unbiased range mapper: config registers, divider chain, tail
// depends on urm_pkg, urm_cell, urm_tail

// Maps each 64-bit entropy word onto the signed range [range_low, range_high]
// by rejection sampling. One item is accepted per cycle unless out_stall holds
// the pipeline; each item passes through the 64-cell restoring divider chain
// (one quotient bit per cell), the rejection stage and the output register. Words
// in the biased top bucket give no result. An empty range gives status 1.
// The whole pipeline holds while a result waits on out_stall. Write the range
// only while idle; derived range facts are registered from the range registers.
module unbiased_range_mapper_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  urm_pkg::cfg_idx_t cfg_index,
  input  urm_pkg::word_t    cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  urm_pkg::word_t    entropy_word,
  output logic              out_valid,
  input  logic              out_stall,
  output urm_pkg::word_t    value,
  output logic              status
);
  import urm_pkg::*;

  word_t       range_low;
  word_t       range_high;
  range_info_t info;
  word_t       span_calc;
  logic        advance;

  cell_bus_t chain [WordW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= '0;
      range_high <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RANGE_LOW:  range_low  <= cfg_data;
        REG_RANGE_HIGH: range_high <= cfg_data;
        default: ;
      endcase
    end
  end

  assign span_calc = range_high - range_low + word_t'(1);

  always_ff @(posedge clk) begin
    info.low_gt_high <= $signed(range_low) > $signed(range_high);
    info.span_zero   <= span_calc == '0;
    info.non_pow2    <= (span_calc & (span_calc - word_t'(1))) != '0;
    info.span        <= span_calc;
    info.low         <= range_low;
  end

  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  assign chain[0].valid = in_valid;
  assign chain[0].word  = entropy_word;
  assign chain[0].rem   = '0;

  // msb first: cell k brings in word bit WordW-1-k
  for (genvar k = 0; k < WordW; k++) begin : g_cell
    urm_cell #(.BitIdx(WordW - 1 - k)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .span    (info.span),
      .din     (chain[k]),
      .dout    (chain[k+1])
    );
  end

  urm_tail u_tail (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .info      (info),
    .din       (chain[WordW]),
    .out_valid (out_valid),
    .value     (value),
    .status    (status)
  );

endmodule
